// File: design/rbv_pkg.sv
`default_nettype none

package rbv_pkg;

    localparam int IN_WIDTH_DEF = 18;
    localparam int OUT_FRAC_DEF = 16;

    localparam int FRAC       = 30;
    localparam int QONE       = 1 << FRAC;
    localparam int MAG_W      = 32;
    localparam int SQ_W       = 64;
    localparam int RND_W      = 68;
    localparam int NORM_STEPS = 5;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 31;

    localparam int CFG_IDX_W      = 2;
    localparam int TARGET_Z_RESET = 65536;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_Z = 2'd2;

    typedef logic signed [MAG_W-1:0] unit_t;

    // shift right by n, rounding half away from zero
    function automatic logic signed [RND_W-1:0] rnd_shift(input logic signed [RND_W-1:0] v,
                                                          input int n);
        logic [RND_W-1:0] mag;
        logic [RND_W-1:0] half;
        mag = v[RND_W-1] ? RND_W'(-v) : RND_W'(v);
        if (n == 0)
        begin
            return v;
        end
        half = RND_W'(1) << (n - 1);
        mag = (mag + half) >> n;
        return v[RND_W-1] ? -$signed(mag) : $signed(mag);
    endfunction

endpackage

`default_nettype wire

// File: design/rbv_sqrt_cell.sv
`default_nettype none

module rbv_sqrt_cell
    import rbv_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   x_d,
    input  wire logic [MAG_W+1:0]  rem_d,
    input  wire logic [MAG_W-1:0]  root_d,
    input  wire logic [SIDE_W-1:0] side_d,
    output logic      [SQ_W-1:0]   x_q,
    output logic      [MAG_W+1:0]  rem_q,
    output logic      [MAG_W-1:0]  root_q,
    output logic      [SIDE_W-1:0] side_q
);

    logic [MAG_W+3:0]  cand;
    logic [MAG_W+3:0]  trial;
    logic [MAG_W+3:0]  diff;
    logic              ge;
    logic [SQ_W-1:0]   x_reg, x_next;
    logic [MAG_W+1:0]  rem_reg, rem_next;
    logic [MAG_W-1:0]  root_reg, root_next;
    logic [SIDE_W-1:0] side_reg;

    always_comb
    begin
        cand      = {rem_d, x_d[SQ_W-1 -: 2]};
        trial     = {2'b00, root_d, 2'b01};
        diff      = cand - trial;
        ge        = cand >= trial;
        rem_next  = ge ? diff[MAG_W+1:0] : cand[MAG_W+1:0];
        root_next = {root_d[MAG_W-2:0], ge};
        x_next    = {x_d[SQ_W-3:0], 2'b00};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg    <= x_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign x_q    = x_reg;
    assign rem_q  = rem_reg;
    assign root_q = root_reg;
    assign side_q = side_reg;

endmodule

`default_nettype wire

// File: design/rbv_sqrt.sv
`default_nettype none

module rbv_sqrt
    import rbv_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [SQ_W-1:0]   x_d,
    input  wire logic [SIDE_W-1:0] side_d,
    output logic      [MAG_W-1:0]  root_q,
    output logic      [SIDE_W-1:0] side_q
);

    logic [SQ_W-1:0]   x_w    [SQRT_STEPS+1];
    logic [MAG_W+1:0]  rem_w  [SQRT_STEPS+1];
    logic [MAG_W-1:0]  root_w [SQRT_STEPS+1];
    logic [SIDE_W-1:0] side_w [SQRT_STEPS+1];

    assign x_w[0]    = x_d;
    assign rem_w[0]  = '0;
    assign root_w[0] = '0;
    assign side_w[0] = side_d;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_cell
        rbv_sqrt_cell #(
            .SIDE_W (SIDE_W)
        ) u_cell (
            .clk    (clk),
            .rst_n  (rst_n),
            .en     (en),
            .x_d    (x_w[k]),
            .rem_d  (rem_w[k]),
            .root_d (root_w[k]),
            .side_d (side_w[k]),
            .x_q    (x_w[k+1]),
            .rem_q  (rem_w[k+1]),
            .root_q (root_w[k+1]),
            .side_q (side_w[k+1])
        );
    end

    assign root_q = root_w[SQRT_STEPS];
    assign side_q = side_w[SQRT_STEPS];

endmodule

`default_nettype wire

// File: design/rbv_div_cell.sv
`default_nettype none

module rbv_div_cell
    import rbv_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic [MAG_W-1:0]     r_d,
    input  wire logic [DIV_STEPS-1:0] w_d,
    input  wire logic [MAG_W-1:0]     div_d,
    input  wire logic [SIDE_W-1:0]    side_d,
    output logic      [MAG_W-1:0]     r_q,
    output logic      [DIV_STEPS-1:0] w_q,
    output logic      [MAG_W-1:0]     div_q,
    output logic      [SIDE_W-1:0]    side_q
);

    logic [MAG_W:0]       cand;
    logic [MAG_W:0]       diff;
    logic                 ge;
    logic [MAG_W-1:0]     r_reg, r_next;
    logic [DIV_STEPS-1:0] w_reg, w_next;
    logic [MAG_W-1:0]     div_reg;
    logic [SIDE_W-1:0]    side_reg;

    always_comb
    begin
        cand   = {r_d, w_d[DIV_STEPS-1]};
        diff   = cand - {1'b0, div_d};
        ge     = cand >= {1'b0, div_d};
        r_next = ge ? diff[MAG_W-1:0] : cand[MAG_W-1:0];
        w_next = {w_d[DIV_STEPS-2:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= side_d;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r_reg   <= r_next;
            w_reg   <= w_next;
            div_reg <= div_d;
        end
    end

    assign r_q    = r_reg;
    assign w_q    = w_reg;
    assign div_q  = div_reg;
    assign side_q = side_reg;

endmodule

`default_nettype wire

// File: design/rbv_unit.sv
`default_nettype none

module rbv_unit
    import rbv_pkg::*;
#(
    parameter int SIDE_W = 1
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              en,
    input  wire logic [MAG_W-1:0]  mag_d [3],
    input  wire logic [2:0]        sgn_d,
    input  wire logic [SIDE_W-1:0] side_d,
    output unit_t                  u_q [3],
    output logic      [SIDE_W-1:0] side_q
);

    localparam int PW = SIDE_W + 3;
    localparam int QW = PW + 3 * MAG_W;
    localparam int NW = 2 * FRAC + 2;

    logic [MAG_W-1:0] nmag_reg [NORM_STEPS+1][3];
    logic [MAG_W-1:0] nmx_reg  [NORM_STEPS+1];
    logic [PW-1:0]    npw_reg  [NORM_STEPS+1];
    logic [MAG_W-1:0] mx_next;

    logic [SQ_W-1:0]  sq_reg [3];
    logic [MAG_W-1:0] sqmag_reg [3];
    logic [PW-1:0]    sqpw_reg;
    logic [SQ_W-1:0]  sum_reg;
    logic [MAG_W-1:0] summag_reg [3];
    logic [PW-1:0]    sumpw_reg;

    logic [QW-1:0]    rt_side_d, rt_side_q;
    logic [MAG_W-1:0] len;

    logic [NW-1:0]    num_reg [3];
    logic [MAG_W-1:0] len_reg;
    logic [PW-1:0]    numpw_reg;

    logic [DIV_STEPS-1:0] quo_w [3];
    logic [2:0]           sg_w;
    logic [SIDE_W-1:0]    dside_w;

    unit_t             u_reg [3];
    logic [SIDE_W-1:0] side_reg;

    // input stage with largest magnitude
    always_comb
    begin
        mx_next = mag_d[0];
        if (mag_d[1] > mx_next)
        begin
            mx_next = mag_d[1];
        end
        if (mag_d[2] > mx_next)
        begin
            mx_next = mag_d[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            npw_reg[0] <= '0;
        end
        else if (en)
        begin
            npw_reg[0] <= {side_d, sgn_d};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            nmag_reg[0] <= mag_d;
            nmx_reg[0]  <= mx_next;
        end
    end

    // normalize shift, one power of two per stage
    for (genvar k = 0; k < NORM_STEPS; k++)
    begin : g_norm
        localparam int SH = 1 << (NORM_STEPS - 1 - k);
        logic do_shift;

        assign do_shift = nmx_reg[k] < (MAG_W'(1) << (MAG_W - 1 - SH));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                npw_reg[k+1] <= '0;
            end
            else if (en)
            begin
                npw_reg[k+1] <= npw_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    nmag_reg[k+1][i] <= do_shift ? (nmag_reg[k][i] << SH) : nmag_reg[k][i];
                end
                nmx_reg[k+1] <= do_shift ? (nmx_reg[k] << SH) : nmx_reg[k];
            end
        end
    end

    // squares and sum
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sqpw_reg  <= '0;
            sumpw_reg <= '0;
        end
        else if (en)
        begin
            sqpw_reg  <= npw_reg[NORM_STEPS];
            sumpw_reg <= sqpw_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                sq_reg[i]     <= SQ_W'(nmag_reg[NORM_STEPS][i]) * SQ_W'(nmag_reg[NORM_STEPS][i]);
                sqmag_reg[i]  <= nmag_reg[NORM_STEPS][i];
                summag_reg[i] <= sqmag_reg[i];
            end
            sum_reg <= sq_reg[0] + sq_reg[1] + sq_reg[2];
        end
    end

    assign rt_side_d = {sumpw_reg, summag_reg[2], summag_reg[1], summag_reg[0]};

    rbv_sqrt #(
        .SIDE_W (QW)
    ) u_len (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .x_d    (sum_reg),
        .side_d (rt_side_d),
        .root_q (len),
        .side_q (rt_side_q)
    );

    // rounded numerators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            numpw_reg <= '0;
        end
        else if (en)
        begin
            numpw_reg <= rt_side_q[QW-1 -: PW];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                num_reg[i] <= (NW'(rt_side_q[i*MAG_W +: MAG_W]) << FRAC) + NW'(len >> 1);
            end
            len_reg <= len;
        end
    end

    // one quotient bit per cell, one row of cells per component
    for (genvar i = 0; i < 3; i++)
    begin : g_lane
        localparam int LSW = (i == 0) ? SIDE_W + 1 : 1;

        logic [MAG_W-1:0]     r_w [DIV_STEPS+1];
        logic [DIV_STEPS-1:0] w_w [DIV_STEPS+1];
        logic [MAG_W-1:0]     d_w [DIV_STEPS+1];
        logic [LSW-1:0]       s_w [DIV_STEPS+1];

        assign r_w[0] = MAG_W'(num_reg[i][NW-1:DIV_STEPS]);
        assign w_w[0] = num_reg[i][DIV_STEPS-1:0];
        assign d_w[0] = len_reg;

        if (i == 0)
        begin : g_side0
            assign s_w[0]  = {numpw_reg[PW-1:3], numpw_reg[0]};
            assign dside_w = s_w[DIV_STEPS][LSW-1:1];
        end
        else
        begin : g_siden
            assign s_w[0] = numpw_reg[i];
        end

        for (genvar k = 0; k < DIV_STEPS; k++)
        begin : g_cell
            rbv_div_cell #(
                .SIDE_W (LSW)
            ) u_cell (
                .clk    (clk),
                .rst_n  (rst_n),
                .en     (en),
                .r_d    (r_w[k]),
                .w_d    (w_w[k]),
                .div_d  (d_w[k]),
                .side_d (s_w[k]),
                .r_q    (r_w[k+1]),
                .w_q    (w_w[k+1]),
                .div_q  (d_w[k+1]),
                .side_q (s_w[k+1])
            );
        end

        assign quo_w[i] = w_w[DIV_STEPS];
        assign sg_w[i]  = s_w[DIV_STEPS][0];
    end

    // signed result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            side_reg <= '0;
        end
        else if (en)
        begin
            side_reg <= dside_w;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                u_reg[i] <= sg_w[i] ? -unit_t'(quo_w[i]) : unit_t'(quo_w[i]);
            end
        end
    end

    assign u_q    = u_reg;
    assign side_q = side_reg;

endmodule

`default_nettype wire

// File: design/rotation_between_vectors.sv
`default_nettype none

// channel   signals                                        direction
// in        in_valid, in_ready, source_x/y/z               request in
// out       out_valid, out_ready, m00..m22, degenerate     request out
// cfg       cfg_valid, cfg_ready, cfg_index, cfg_data      register write in
//
// one request per cycle while the pipeline is not held; two rows of unit scaling
// (32 square-root cells, 31 divider cells each) and a 32-cell square root for the sine
// reset empties the pipeline and sets the target to (0, 0, 65536)
// the whole pipeline holds only when its last stage is full and the output waits

module rotation_between_vectors
    import rbv_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    parameter int OUT_FRAC = OUT_FRAC_DEF
)
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       in_valid,
    output logic                            in_ready,
    input  wire logic signed [IN_WIDTH-1:0] source_x,
    input  wire logic signed [IN_WIDTH-1:0] source_y,
    input  wire logic signed [IN_WIDTH-1:0] source_z,
    output logic                            out_valid,
    input  wire logic                       out_ready,
    output logic signed [OUT_FRAC+1:0]      m00,
    output logic signed [OUT_FRAC+1:0]      m01,
    output logic signed [OUT_FRAC+1:0]      m02,
    output logic signed [OUT_FRAC+1:0]      m10,
    output logic signed [OUT_FRAC+1:0]      m11,
    output logic signed [OUT_FRAC+1:0]      m12,
    output logic signed [OUT_FRAC+1:0]      m20,
    output logic signed [OUT_FRAC+1:0]      m21,
    output logic signed [OUT_FRAC+1:0]      m22,
    output logic                            degenerate,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [IN_WIDTH-1:0]        cfg_data
);

    localparam int OW = OUT_FRAC + 2;
    localparam int RS = FRAC - OUT_FRAC;

    typedef struct packed {
        logic vld;
        logic zero;
    } s_side_t;

    typedef struct packed {
        logic                   vld;
        logic                   deg;
        logic                   czero;
        unit_t                  cs;
        logic [2:0]             csgn;
        logic [2:0][MAG_W-1:0]  cmag;
    } c_side_t;

    typedef struct packed {
        logic           vld;
        logic           deg;
        logic           czero;
        unit_t          cs;
        logic [FRAC:0]  sn;
    } k_side_t;

    logic en;

    logic signed [IN_WIDTH-1:0] tgt_reg [3];
    logic signed [IN_WIDTH-1:0] src [3];
    logic [MAG_W-1:0]           smag [3];
    logic [MAG_W-1:0]           tmag [3];
    logic [2:0]                 ssgn, tsgn;
    logic                       szero, tzero;
    s_side_t                    s_side_d, s_side_q;
    logic                       t_side_q;
    unit_t                      a [3];
    unit_t                      b [3];

    logic                    v1_reg, v2_reg, v3_reg, v4_reg;
    logic                    v6_reg, v7_reg, v8_reg, v9_reg, v10_reg;
    logic                    deg1_reg, deg2_reg, deg3_reg, deg4_reg;
    logic signed [SQ_W-1:0]  pd_reg [3];
    logic signed [SQ_W-1:0]  px_reg [6];
    logic signed [SQ_W+1:0]  dot_reg;
    logic signed [SQ_W:0]    crs_reg [3];
    logic signed [RND_W-1:0] cs_rnd;
    unit_t                   cs_next;
    unit_t                   cs3_reg, cs4_reg;
    logic signed [MAG_W:0]   c_reg [3];
    logic [MAG_W-1:0]        cmag_next [3];
    logic [MAG_W-1:0]        cmag_reg [3];
    logic [2:0]              csgn_reg;
    logic [SQ_W-1:0]         csq_reg [3];
    logic                    czero4_reg;
    logic [SQ_W-1:0]         csum_reg;
    c_side_t                 c_side_reg, c_side_q;
    logic [MAG_W-1:0]        sroot;
    logic [MAG_W-1:0]        kmag [3];
    k_side_t                 k_side_d, k_side_q;
    unit_t                   k [3];

    logic signed [SQ_W-1:0]  kk_reg [6];
    logic signed [SQ_W-1:0]  kw_reg [3];
    logic signed [MAG_W:0]   omc6_reg, omc7_reg;
    unit_t                   cs6_reg, cs7_reg, cs8_reg, cs9_reg;
    logic                    cz6_reg, cz7_reg, cz8_reg, cz9_reg;
    logic                    dg6_reg, dg7_reg, dg8_reg, dg9_reg, dg10_reg;
    unit_t                   kr_reg [6];
    unit_t                   w7_reg [3];
    unit_t                   w8_reg [3];
    unit_t                   w9_reg [3];
    logic signed [MAG_W+32:0] kq_reg [6];
    logic signed [MAG_W:0]   q_reg [6];
    logic signed [MAG_W+1:0] r_reg [9];
    logic signed [MAG_W+1:0] r_next [9];

    logic                    out_valid_reg;
    logic signed [OW-1:0]    m_reg [9];
    logic signed [OW-1:0]    m_next [9];
    logic                    deg_out_reg;
    logic                    load;

    assign en        = !(v10_reg && out_valid_reg && !out_ready);
    assign in_ready  = en;
    assign cfg_ready = 1'b1;
    assign load      = v10_reg && en;

    // target registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg[0] <= '0;
            tgt_reg[1] <= '0;
            tgt_reg[2] <= IN_WIDTH'(TARGET_Z_RESET);
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TARGET_X: tgt_reg[0] <= cfg_data;
                REG_TARGET_Y: tgt_reg[1] <= cfg_data;
                REG_TARGET_Z: tgt_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // magnitudes and signs
    assign src[0] = source_x;
    assign src[1] = source_y;
    assign src[2] = source_z;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            ssgn[i] = src[i][IN_WIDTH-1];
            tsgn[i] = tgt_reg[i][IN_WIDTH-1];
            smag[i] = ssgn[i] ? MAG_W'(-unit_t'(src[i])) : MAG_W'(unit_t'(src[i]));
            tmag[i] = tsgn[i] ? MAG_W'(-unit_t'(tgt_reg[i])) : MAG_W'(unit_t'(tgt_reg[i]));
        end
        szero = (src[0] == '0) && (src[1] == '0) && (src[2] == '0);
        tzero = (tgt_reg[0] == '0) && (tgt_reg[1] == '0) && (tgt_reg[2] == '0);
        s_side_d.vld  = in_valid;
        s_side_d.zero = szero;
    end

    rbv_unit #(
        .SIDE_W ($bits(s_side_t))
    ) u_src (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .mag_d  (smag),
        .sgn_d  (ssgn),
        .side_d (s_side_d),
        .u_q    (a),
        .side_q (s_side_q)
    );

    rbv_unit #(
        .SIDE_W (1)
    ) u_tgt (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .mag_d  (tmag),
        .sgn_d  (tsgn),
        .side_d (tzero),
        .u_q    (b),
        .side_q (t_side_q)
    );

    // valid line
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            v3_reg  <= 1'b0;
            v4_reg  <= 1'b0;
            v6_reg  <= 1'b0;
            v7_reg  <= 1'b0;
            v8_reg  <= 1'b0;
            v9_reg  <= 1'b0;
            v10_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg  <= s_side_q.vld;
            v2_reg  <= v1_reg;
            v3_reg  <= v2_reg;
            v4_reg  <= v3_reg;
            v6_reg  <= k_side_q.vld;
            v7_reg  <= v6_reg;
            v8_reg  <= v7_reg;
            v9_reg  <= v8_reg;
            v10_reg <= v9_reg;
        end
    end

    // cosine, cross product and its squared length
    always_comb
    begin
        cs_rnd = rnd_shift(RND_W'(dot_reg), FRAC);
        if (cs_rnd > RND_W'(QONE))
        begin
            cs_next = unit_t'(QONE);
        end
        else if (cs_rnd < -RND_W'(QONE))
        begin
            cs_next = -unit_t'(QONE);
        end
        else
        begin
            cs_next = unit_t'(cs_rnd);
        end
        for (int i = 0; i < 3; i++)
        begin
            cmag_next[i] = c_reg[i][MAG_W] ? MAG_W'(-c_reg[i]) : MAG_W'(c_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            deg1_reg <= s_side_q.zero || t_side_q;
            for (int i = 0; i < 3; i++)
            begin
                pd_reg[i] <= a[i] * b[i];
            end
            px_reg[0] <= a[1] * b[2];
            px_reg[1] <= a[2] * b[1];
            px_reg[2] <= a[2] * b[0];
            px_reg[3] <= a[0] * b[2];
            px_reg[4] <= a[0] * b[1];
            px_reg[5] <= a[1] * b[0];

            deg2_reg <= deg1_reg;
            dot_reg  <= (SQ_W+2)'(pd_reg[0]) + (SQ_W+2)'(pd_reg[1]) + (SQ_W+2)'(pd_reg[2]);
            for (int i = 0; i < 3; i++)
            begin
                crs_reg[i] <= (SQ_W+1)'(px_reg[2*i]) - (SQ_W+1)'(px_reg[2*i+1]);
            end

            deg3_reg <= deg2_reg;
            cs3_reg  <= cs_next;
            for (int i = 0; i < 3; i++)
            begin
                c_reg[i] <= (MAG_W+1)'(rnd_shift(RND_W'(crs_reg[i]), FRAC));
            end

            deg4_reg   <= deg3_reg;
            cs4_reg    <= cs3_reg;
            czero4_reg <= (c_reg[0] == '0) && (c_reg[1] == '0) && (c_reg[2] == '0);
            for (int i = 0; i < 3; i++)
            begin
                cmag_reg[i] <= cmag_next[i];
                csgn_reg[i] <= c_reg[i][MAG_W];
                csq_reg[i]  <= SQ_W'(cmag_next[i]) * SQ_W'(cmag_next[i]);
            end

            csum_reg <= csq_reg[0] + csq_reg[1] + csq_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_side_reg <= '0;
        end
        else if (en)
        begin
            c_side_reg.vld   <= v4_reg;
            c_side_reg.deg   <= deg4_reg;
            c_side_reg.czero <= czero4_reg;
            c_side_reg.cs    <= cs4_reg;
            c_side_reg.csgn  <= csgn_reg;
            for (int i = 0; i < 3; i++)
            begin
                c_side_reg.cmag[i] <= cmag_reg[i];
            end
        end
    end

    // sine
    rbv_sqrt #(
        .SIDE_W ($bits(c_side_t))
    ) u_sin (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .x_d    (csum_reg),
        .side_d (c_side_reg),
        .root_q (sroot),
        .side_q (c_side_q)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            kmag[i] = c_side_q.cmag[i];
        end
        k_side_d.vld   = c_side_q.vld;
        k_side_d.deg   = c_side_q.deg;
        k_side_d.czero = c_side_q.czero;
        k_side_d.cs    = c_side_q.cs;
        k_side_d.sn    = (sroot > MAG_W'(QONE)) ? (FRAC+1)'(QONE) : sroot[FRAC:0];
    end

    // rotation axis
    rbv_unit #(
        .SIDE_W ($bits(k_side_t))
    ) u_axis (
        .clk    (clk),
        .rst_n  (rst_n),
        .en     (en),
        .mag_d  (kmag),
        .sgn_d  (c_side_q.csgn),
        .side_d (k_side_d),
        .u_q    (k),
        .side_q (k_side_q)
    );

    // matrix terms
    always_comb
    begin
        if (cz9_reg)
        begin
            for (int i = 0; i < 9; i++)
            begin
                r_next[i] = '0;
            end
            r_next[0] = (MAG_W+2)'(cs9_reg);
            r_next[4] = (MAG_W+2)'(cs9_reg);
            r_next[8] = (MAG_W+2)'(cs9_reg);
        end
        else
        begin
            r_next[0] = (MAG_W+2)'(cs9_reg) + (MAG_W+2)'(q_reg[0]);
            r_next[1] = (MAG_W+2)'(q_reg[1]) - (MAG_W+2)'(w9_reg[2]);
            r_next[2] = (MAG_W+2)'(q_reg[2]) + (MAG_W+2)'(w9_reg[1]);
            r_next[3] = (MAG_W+2)'(q_reg[1]) + (MAG_W+2)'(w9_reg[2]);
            r_next[4] = (MAG_W+2)'(cs9_reg) + (MAG_W+2)'(q_reg[3]);
            r_next[5] = (MAG_W+2)'(q_reg[4]) - (MAG_W+2)'(w9_reg[0]);
            r_next[6] = (MAG_W+2)'(q_reg[2]) - (MAG_W+2)'(w9_reg[1]);
            r_next[7] = (MAG_W+2)'(q_reg[4]) + (MAG_W+2)'(w9_reg[0]);
            r_next[8] = (MAG_W+2)'(cs9_reg) + (MAG_W+2)'(q_reg[5]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kk_reg[0] <= k[0] * k[0];
            kk_reg[1] <= k[0] * k[1];
            kk_reg[2] <= k[0] * k[2];
            kk_reg[3] <= k[1] * k[1];
            kk_reg[4] <= k[1] * k[2];
            kk_reg[5] <= k[2] * k[2];
            for (int i = 0; i < 3; i++)
            begin
                kw_reg[i] <= k[i] * $signed(MAG_W'(k_side_q.sn));
            end
            omc6_reg <= (MAG_W+1)'(QONE) - (MAG_W+1)'(k_side_q.cs);
            cs6_reg  <= k_side_q.cs;
            cz6_reg  <= k_side_q.czero;
            dg6_reg  <= k_side_q.deg;

            for (int j = 0; j < 6; j++)
            begin
                kr_reg[j] <= unit_t'(rnd_shift(RND_W'(kk_reg[j]), FRAC));
            end
            for (int i = 0; i < 3; i++)
            begin
                w7_reg[i] <= unit_t'(rnd_shift(RND_W'(kw_reg[i]), FRAC));
            end
            omc7_reg <= omc6_reg;
            cs7_reg  <= cs6_reg;
            cz7_reg  <= cz6_reg;
            dg7_reg  <= dg6_reg;

            for (int j = 0; j < 6; j++)
            begin
                kq_reg[j] <= kr_reg[j] * omc7_reg;
            end
            w8_reg  <= w7_reg;
            cs8_reg <= cs7_reg;
            cz8_reg <= cz7_reg;
            dg8_reg <= dg7_reg;

            for (int j = 0; j < 6; j++)
            begin
                q_reg[j] <= (MAG_W+1)'(rnd_shift(RND_W'(kq_reg[j]), FRAC));
            end
            w9_reg  <= w8_reg;
            cs9_reg <= cs8_reg;
            cz9_reg <= cz8_reg;
            dg9_reg <= dg8_reg;

            r_reg    <= r_next;
            dg10_reg <= dg9_reg;
        end
    end

    // output rounding, saturation and zero-length override
    always_comb
    begin
        logic signed [RND_W-1:0] v;
        for (int i = 0; i < 9; i++)
        begin
            v = rnd_shift(RND_W'(r_reg[i]), RS);
            if (v > (RND_W'(1) <<< OUT_FRAC))
            begin
                v = RND_W'(1) <<< OUT_FRAC;
            end
            else if (v < -(RND_W'(1) <<< OUT_FRAC))
            begin
                v = -(RND_W'(1) <<< OUT_FRAC);
            end
            m_next[i] = OW'(v);
            if (dg10_reg)
            begin
                m_next[i] = (i % 4 == 0) ? (OW'(1) << OUT_FRAC) : '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            m_reg       <= m_next;
            deg_out_reg <= dg10_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign m00        = m_reg[0];
    assign m01        = m_reg[1];
    assign m02        = m_reg[2];
    assign m10        = m_reg[3];
    assign m11        = m_reg[4];
    assign m12        = m_reg[5];
    assign m20        = m_reg[6];
    assign m21        = m_reg[7];
    assign m22        = m_reg[8];
    assign degenerate = deg_out_reg;

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`default_nettype none

module tb_top
    import rbv_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int IW = 18;
    localparam int OF = 16;
    localparam int OW = OF + 2;
    localparam int LATENCY = 189;

    typedef logic signed [IW-1:0] comp_t;
    typedef logic signed [OW-1:0] entry_t;

    typedef struct packed {
        comp_t x;
        comp_t y;
        comp_t z;
    } vec_t;

    typedef struct packed {
        entry_t [8:0] m;
        logic         degen;
    } matrix_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    comp_t source_x = '0;
    comp_t source_y = '0;
    comp_t source_z = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic degenerate;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TARGET_X;
    logic [IW-1:0] cfg_data = '0;

    rotation_between_vectors #(.IN_WIDTH(IW), .OUT_FRAC(OF)) dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .source_x(source_x), .source_y(source_y), .source_z(source_z),
        .out_valid(out_valid), .out_ready(out_ready),
        .m00(m00), .m01(m01), .m02(m02), .m10(m10), .m11(m11), .m12(m12),
        .m20(m20), .m21(m21), .m22(m22), .degenerate(degenerate),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    vec_t    vec_pending[$];
    matrix_t matrix_expected[$];
    vec_t    target;
    int      mismatch_count = 0;
    int      sent_count = 0;

    function automatic longint round_shift(longint v, int n);
        longint mag;
        if (n == 0)
            return v;
        mag = v < 0 ? -v : v;
        mag = (mag + (64'sd1 <<< (n - 1))) >>> n;
        return v < 0 ? -mag : mag;
    endfunction

    function automatic longint int_sqrt(longint unsigned x);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x)
            b >>= 2;
        while (b != 0)
        begin
            if (x >= r + b)
            begin
                x -= r + b;
                r = (r >> 1) + b;
            end
            else
                r >>= 1;
            b >>= 2;
        end
        return longint'(r);
    endfunction

    task automatic to_unit(input longint v[3], output longint u[3]);
        longint unsigned mag[3];
        longint unsigned mx;
        longint unsigned acc;
        longint unsigned len;
        longint unsigned q;
        mx = 0;
        acc = 0;
        for (int i = 0; i < 3; i++)
        begin
            mag[i] = v[i] < 0 ? -v[i] : v[i];
            if (mag[i] > mx)
                mx = mag[i];
        end
        while (mx < (64'd1 << 30))
        begin
            mx <<= 1;
            for (int i = 0; i < 3; i++)
                mag[i] <<= 1;
        end
        for (int i = 0; i < 3; i++)
            acc += mag[i] * mag[i];
        len = int_sqrt(acc);
        for (int i = 0; i < 3; i++)
        begin
            q = ((mag[i] << 30) + (len >> 1)) / len;
            u[i] = v[i] < 0 ? -longint'(q) : longint'(q);
        end
    endtask

    task automatic predict_rotation(input vec_t src, output matrix_t res);
        longint s[3], t[3], a[3], b[3], c[3], k[3], r[9], w[3];
        longint qone, cs, sn, omc, dotp, lim, v;
        longint unsigned csq;
        bit czero;
        qone = 64'sd1 <<< 30;
        lim = 64'sd1 <<< OF;
        s[0] = src.x; s[1] = src.y; s[2] = src.z;
        t[0] = target.x; t[1] = target.y; t[2] = target.z;
        res = '0;
        if ((s[0] == 0 && s[1] == 0 && s[2] == 0) || (t[0] == 0 && t[1] == 0 && t[2] == 0))
        begin
            for (int i = 0; i < 9; i++)
                res.m[i] = (i % 4 == 0) ? entry_t'(lim) : '0;
            res.degen = 1'b1;
            return;
        end
        to_unit(s, a);
        to_unit(t, b);
        dotp = a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
        cs = round_shift(dotp, 30);
        if (cs > qone) cs = qone;
        if (cs < -qone) cs = -qone;
        c[0] = round_shift(a[1] * b[2] - a[2] * b[1], 30);
        c[1] = round_shift(a[2] * b[0] - a[0] * b[2], 30);
        c[2] = round_shift(a[0] * b[1] - a[1] * b[0], 30);
        czero = (c[0] == 0 && c[1] == 0 && c[2] == 0);
        if (czero)
        begin
            for (int i = 0; i < 9; i++)
                r[i] = (i % 4 == 0) ? cs : 0;
        end
        else
        begin
            csq = 0;
            for (int i = 0; i < 3; i++)
                csq += longint'(c[i] * c[i]);
            sn = int_sqrt(csq);
            if (sn > qone) sn = qone;
            to_unit(c, k);
            omc = qone - cs;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                    r[i * 3 + j] = round_shift(round_shift(k[i] * k[j], 30) * omc, 30);
                w[i] = round_shift(k[i] * sn, 30);
            end
            r[0] += cs;
            r[1] -= w[2];
            r[2] += w[1];
            r[3] += w[2];
            r[4] += cs;
            r[5] -= w[0];
            r[6] -= w[1];
            r[7] += w[0];
            r[8] += cs;
        end
        for (int i = 0; i < 9; i++)
        begin
            v = round_shift(r[i], 30 - OF);
            if (v > lim) v = lim;
            if (v < -lim) v = -lim;
            res.m[i] = entry_t'(v);
        end
        res.degen = 1'b0;
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        mismatch_count++;
        $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    endtask

    // driver
    int in_wait = 0;
    always @(posedge clk)
    begin
        matrix_t pred;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                predict_rotation({source_x, source_y, source_z}, pred);
                matrix_expected.push_back(pred);
                sent_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (in_wait > 0)
                begin
                    in_valid <= 1'b0;
                    in_wait <= in_wait - 1;
                end
                else if (vec_pending.size() > 0)
                begin
                    vec_t nv;
                    nv = vec_pending.pop_front();
                    in_valid <= 1'b1;
                    source_x <= nv.x;
                    source_y <= nv.y;
                    source_z <= nv.z;
                    in_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor
    int out_wait = 0;
    always @(posedge clk)
    begin
        matrix_t got;
        matrix_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got.m = {m22, m21, m20, m12, m11, m10, m02, m01, m00};
                got.degen = degenerate;
                if (matrix_expected.size() == 0)
                    report_mismatch("unexpected matrix", 0, 0);
                else
                begin
                    want = matrix_expected.pop_front();
                    for (int i = 0; i < 9; i++)
                        if (got.m[i] !== want.m[i])
                            report_mismatch($sformatf("m%0d%0d", i / 3, i % 3),
                                            got.m[i], want.m[i]);
                    if (got.degen !== want.degen)
                        report_mismatch("degenerate", got.degen, want.degen);
                end
                out_wait <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
                out_ready <= 1'b0;
            end
            else if (out_wait > 0)
            begin
                out_wait <= out_wait - 1;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_target(input logic [CFG_IDX_W-1:0] idx, input logic [IW-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_TARGET_X: target.x = val;
            REG_TARGET_Y: target.y = val;
            REG_TARGET_Z: target.z = val;
            default: ;
        endcase
    endtask

    task automatic set_target(input comp_t x, input comp_t y, input comp_t z);
        write_target(REG_TARGET_X, x);
        write_target(REG_TARGET_Y, y);
        write_target(REG_TARGET_Z, z);
    endtask

    function automatic comp_t rand_comp();
        case ($urandom_range(0, 5))
            0: return comp_t'($urandom_range(0, 7)) - comp_t'(3);
            1: return comp_t'(-131072);
            2: return comp_t'(131071);
            default: return comp_t'($urandom);
        endcase
    endfunction

    task automatic queue_random(input int n);
        vec_t v;
        for (int i = 0; i < n; i++)
        begin
            v.x = rand_comp();
            v.y = rand_comp();
            v.z = rand_comp();
            case ($urandom_range(0, 9))
                0: v = '0;
                1: v = {target.x, target.y, target.z};
                2: v = {-target.x, -target.y, -target.z};
                default: ;
            endcase
            vec_pending.push_back(v);
        end
    endtask

    task automatic drain();
        wait (vec_pending.size() == 0 && !in_valid && matrix_expected.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
    endtask

    localparam comp_t CMAX = 131071;
    localparam comp_t CMIN = -131072;

    initial
    begin
        target = {comp_t'(0), comp_t'(0), comp_t'(TARGET_Z_RESET)};
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed: axes, zero, parallel, opposite, extremes
        vec_pending.push_back({comp_t'(0), comp_t'(0), comp_t'(1)});
        vec_pending.push_back({comp_t'(0), comp_t'(0), comp_t'(-5)});
        vec_pending.push_back({comp_t'(0), comp_t'(0), comp_t'(0)});
        vec_pending.push_back({comp_t'(1), comp_t'(0), comp_t'(0)});
        vec_pending.push_back({comp_t'(0), comp_t'(-1), comp_t'(0)});
        vec_pending.push_back({CMAX, CMAX, CMAX});
        vec_pending.push_back({CMIN, CMIN, CMIN});
        vec_pending.push_back({CMIN, CMAX, comp_t'(0)});
        vec_pending.push_back({comp_t'(1), comp_t'(1), CMAX});
        vec_pending.push_back({comp_t'(-1), comp_t'(0), CMIN});
        vec_pending.push_back({comp_t'(3), comp_t'(4), comp_t'(0)});
        vec_pending.push_back({comp_t'(0), comp_t'(0), CMAX});
        vec_pending.push_back({comp_t'(0), comp_t'(0), CMIN});
        drain();

        set_target(CMIN, comp_t'(0), comp_t'(0));
        vec_pending.push_back({CMAX, comp_t'(0), comp_t'(0)});
        vec_pending.push_back({CMIN, comp_t'(0), comp_t'(0)});
        vec_pending.push_back({comp_t'(0), CMAX, CMIN});
        queue_random(100);
        drain();

        set_target(comp_t'(0), comp_t'(0), comp_t'(0));
        vec_pending.push_back({comp_t'(1), comp_t'(2), comp_t'(3)});
        queue_random(10);
        drain();

        set_target(CMAX, CMAX, CMAX);
        queue_random(100);
        drain();

        set_target(comp_t'(1), comp_t'(-1), CMIN);
        queue_random(90);
        drain();

        set_target(rand_comp(), rand_comp(), rand_comp());
        queue_random(100);
        drain();

        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire
